// File: design/max_rectangle_binary_matrix_core_macros.svh
// Assertion macros for the maximal rectangle core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef MAX_RECTANGLE_BINARY_MATRIX_CORE_MACROS_SVH
`define MAX_RECTANGLE_BINARY_MATRIX_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset
`define MRBM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset
`define MRBM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mrbm_pkg.sv
// Shared constants, types and width helpers for the maximal rectangle core.
// No dependencies.
package mrbm_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int ROW_WIDTH_W = 7;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 7'd64;

    localparam int AREA_W = 17;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic pop;
        logic clear;
    } best_cmd_t;

    function automatic int addr_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// File: design/max_rectangle_binary_matrix_core.sv
// Top level of the maximal rectangle core: configuration, output register, checks.
// Depends on mrbm_pkg, mrbm_ctrl, mrbm_best and the assertion macro header.
//
// Cells of a binary matrix enter one item at a time in row-major order; on the item
// marked tlast the core emits the area of the largest all-ones rectangle and starts
// afresh with the next item. Rows are row_width columns wide (0 acts as 1, values above
// MAX_COLS act as MAX_COLS). Each cell passes through accept, height read-modify-write
// and push, with one extra step for every bar popped from the histogram stack; at the
// end of a row the stack drains at one entry per cycle. Every column is pushed and
// popped once per row, and the stack memory allows one pop per cycle. After the last
// cell the area moves into the output register, which waits there while the next
// matrix already streams in; a second area waits until it is taken.
`include "max_rectangle_binary_matrix_core_macros.svh"

module max_rectangle_binary_matrix_core #(
    parameter int MAX_COLS = mrbm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = mrbm_pkg::MAX_ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mrbm_pkg::ROW_WIDTH_W-1:0] cfg_wdata,     // row_width
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mrbm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] cell_req
    input  logic                             s_axis_tlast,  // last_cell
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mrbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [16:0] max_area
);

    import mrbm_pkg::*;

    localparam int H_W    = $clog2(MAX_ROWS + 1);
    localparam int SPAN_W = $clog2(MAX_COLS + 1);

    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [AREA_W-1:0]      out_area_reg;
    logic                   result_req, result_ack;
    best_cmd_t              cmd;
    logic [H_W-1:0]         pop_height;
    logic [SPAN_W-1:0]      pop_span;
    logic [AREA_W-1:0]      best_area;

    mrbm_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_width  (row_width_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .cell_req   (s_axis_tdata[0]),
        .last_cell  (s_axis_tlast),
        .result_req (result_req),
        .result_ack (result_ack),
        .cmd        (cmd),
        .pop_height (pop_height),
        .pop_span   (pop_span)
    );

    mrbm_best #(
        .H_W    (H_W),
        .SPAN_W (SPAN_W)
    ) u_best (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pop_height (pop_height),
        .pop_span   (pop_span),
        .best_area  (best_area)
    );

    assign result_ack = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (result_req && result_ack)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                row_width_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_req && result_ack)
        begin
            out_area_reg <= best_area;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - AREA_W){1'b0}}, out_area_reg};

    `MRBM_ASSERT_IMP(a_no_accept_when_pending, s_axis_tready, !result_req, "item taken with result pending")
    `MRBM_ASSERT_NXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")
    `MRBM_ASSERT_NXT(a_best_cleared_on_result, result_req && result_ack, m_axis_tvalid && (best_area == '0), "best area not cleared after result")

endmodule

// File: design/mrbm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on mrbm_pkg for address width.
module mrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = mrbm_pkg::addr_bits(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/mrbm_best.sv
// Area unit: bar height times span, saturated, folded into the running best.
// Depends on mrbm_pkg.
module mrbm_best #(
    parameter int H_W    = 11,
    parameter int SPAN_W = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mrbm_pkg::best_cmd_t         cmd,
    input  logic [H_W-1:0]              pop_height,
    input  logic [SPAN_W-1:0]           pop_span,
    output logic [mrbm_pkg::AREA_W-1:0] best_area
);

    import mrbm_pkg::*;

    localparam int PROD_W = H_W + SPAN_W;
    localparam int CMP_W  = (PROD_W > AREA_W) ? PROD_W : AREA_W;

    logic [PROD_W-1:0] prod;
    logic [AREA_W-1:0] area;
    logic [AREA_W-1:0] best_reg;
    logic [AREA_W-1:0] best_next;

    always_comb
    begin
        prod = PROD_W'(pop_height) * PROD_W'(pop_span);
        if (CMP_W'(prod) > CMP_W'(AREA_MAX))
        begin
            area = AREA_MAX;
        end
        else
        begin
            area = AREA_W'(prod);
        end

        best_next = best_reg;
        if (cmd.clear)
        begin
            best_next = '0;
        end
        else if (cmd.pop && (area > best_reg))
        begin
            best_next = area;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best_area = best_reg;

endmodule

// File: design/mrbm_ctrl.sv
// Sequencer: column height read-modify-write and the histogram index stack.
// Depends on mrbm_pkg and mrbm_ram; drives mrbm_best through a command struct.
module mrbm_ctrl #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 1024,
    localparam int H_W     = $clog2(MAX_ROWS + 1),
    localparam int SPAN_W  = $clog2(MAX_COLS + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [mrbm_pkg::ROW_WIDTH_W-1:0] row_width,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cell_req,
    input  logic                             last_cell,
    output logic                             result_req,
    input  logic                             result_ack,
    output mrbm_pkg::best_cmd_t              cmd,
    output logic [H_W-1:0]                   pop_height,
    output logic [SPAN_W-1:0]                pop_span
);

    import mrbm_pkg::*;

    localparam int COL_W   = addr_bits(MAX_COLS);
    localparam int DEPTH_W = SPAN_W;
    localparam int WW      = (SPAN_W > ROW_WIDTH_W) ? SPAN_W : ROW_WIDTH_W;
    localparam int ST_W    = COL_W + H_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_POP   = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic                top_ram_reg, top_ram_next;
    logic [MAX_COLS-1:0] hvalid_reg, hvalid_next;
    logic                last_reg, last_next;
    logic                cell_reg, cell_next;
    logic [H_W-1:0]      h_reg, h_next;
    logic [COL_W-1:0]    left_reg, left_next;
    logic [COL_W-1:0]    top_left_reg, top_left_next;
    logic [H_W-1:0]      top_h_reg, top_h_next;

    logic                hram_re, hram_we;
    logic [H_W-1:0]      hram_rdata, hram_wdata;
    logic                st_re, st_we;
    logic [COL_W-1:0]    st_raddr, st_waddr;
    logic [ST_W-1:0]     st_rdata, st_wdata;

    logic [COL_W-1:0]    top_left;
    logic [H_W-1:0]      top_h;
    logic [H_W-1:0]      h_old, h_new;
    logic [WW-1:0]       rw_ext, w_eff, col_p1_w;
    logic [SPAN_W-1:0]   col_p1, pop_end;
    logic [DEPTH_W-1:0]  depth_m2;
    logic                row_end;
    logic                pop_en;

    mrbm_ram #(
        .WIDTH (H_W),
        .DEPTH (MAX_COLS)
    ) u_height_ram (
        .clk   (clk),
        .we    (hram_we),
        .waddr (col_reg),
        .wdata (hram_wdata),
        .re    (hram_re),
        .raddr (col_reg),
        .rdata (hram_rdata)
    );

    mrbm_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_COLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    always_comb
    begin
        top_left = top_ram_reg ? st_rdata[ST_W-1:H_W] : top_left_reg;
        top_h    = top_ram_reg ? st_rdata[H_W-1:0]    : top_h_reg;

        h_old = hvalid_reg[col_reg] ? hram_rdata : '0;
        if (!cell_reg)
        begin
            h_new = '0;
        end
        else if (h_old >= H_W'(MAX_ROWS))
        begin
            h_new = H_W'(MAX_ROWS);
        end
        else
        begin
            h_new = H_W'(h_old + 1'b1);
        end

        rw_ext = WW'(row_width);
        if (rw_ext == '0)
        begin
            w_eff = WW'(1);
        end
        else if (rw_ext > WW'(MAX_COLS))
        begin
            w_eff = WW'(MAX_COLS);
        end
        else
        begin
            w_eff = rw_ext;
        end
        col_p1   = SPAN_W'(col_reg) + 1'b1;
        col_p1_w = WW'(col_p1);
        row_end  = last_reg || (col_p1_w >= w_eff);
        depth_m2 = depth_reg - DEPTH_W'(2);
    end

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        depth_next    = depth_reg;
        top_ram_next  = top_ram_reg;
        hvalid_next   = hvalid_reg;
        last_next     = last_reg;
        cell_next     = cell_reg;
        h_next        = h_reg;
        left_next     = left_reg;
        top_left_next = top_left_reg;
        top_h_next    = top_h_reg;

        hram_re    = 1'b0;
        hram_we    = 1'b0;
        hram_wdata = h_new;
        st_re      = 1'b0;
        st_we      = 1'b0;
        st_raddr   = COL_W'(depth_m2);
        st_waddr   = COL_W'(depth_reg);
        st_wdata   = {left_reg, h_reg};

        pop_en     = 1'b0;
        pop_end    = SPAN_W'(col_reg);
        in_ready   = 1'b0;
        result_req = 1'b0;
        cmd.clear  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cell_next  = cell_req;
                    last_next  = last_cell;
                    left_next  = col_reg;
                    hram_re    = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                hram_we             = 1'b1;
                hvalid_next[col_reg] = 1'b1;
                h_next              = h_new;
                state_next          = ST_POP;
            end
            ST_POP:
            begin
                if ((depth_reg != '0) && (top_h >= h_reg))
                begin
                    pop_en = 1'b1;
                end
                else
                begin
                    st_we         = 1'b1;
                    top_left_next = left_reg;
                    top_h_next    = h_reg;
                    top_ram_next  = 1'b0;
                    depth_next    = depth_reg + 1'b1;
                    if (row_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                pop_end = col_p1;
                if (depth_reg != '0)
                begin
                    pop_en = 1'b1;
                end
                else
                begin
                    col_next   = '0;
                    state_next = last_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                result_req = 1'b1;
                if (result_ack)
                begin
                    hvalid_next = '0;
                    cmd.clear   = 1'b1;
                    last_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // drop the top bar; the entry below becomes the top on the next cycle
        if (pop_en)
        begin
            depth_next   = depth_reg - 1'b1;
            left_next    = top_left;
            top_ram_next = 1'b1;
            st_re        = (depth_reg > DEPTH_W'(1));
        end

        cmd.pop    = pop_en;
        pop_height = top_h;
        pop_span   = pop_end - SPAN_W'(top_left);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            depth_reg   <= '0;
            top_ram_reg <= 1'b0;
            hvalid_reg  <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            depth_reg   <= depth_next;
            top_ram_reg <= top_ram_next;
            hvalid_reg  <= hvalid_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg     <= cell_next;
        h_reg        <= h_next;
        left_reg     <= left_next;
        top_left_reg <= top_left_next;
        top_h_reg    <= top_h_next;
    end

endmodule
